@@ rtl/dda_line_alpha_blend_unit_macros.svh @@
// Assertion macros shared by the line blend unit.
`ifndef DDA_LINE_ALPHA_BLEND_UNIT_MACROS_SVH
`define DDA_LINE_ALPHA_BLEND_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DLA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DLA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/dla_pkg.sv @@
// Package: shared types and constants of the line blend unit.
package dla_pkg;

    localparam int OFS_W      = 26;
    localparam int COLOR_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int ALPHA_W    = 9;
    localparam int STRIDE_W   = 15;
    localparam int BPP_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_COLOR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLEND_ALPHA = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BPP         = 2'd3;

    localparam logic [CFG_DATA_W-1:0] LINE_COLOR_RST = 24'hFF0000;
    localparam logic [ALPHA_W-1:0]    ALPHA_ONE      = 9'd256;
    localparam logic [STRIDE_W-1:0]   ROW_STRIDE_RST = 15'd4096;
    localparam logic [BPP_W-1:0]      BPP_RST        = 3'd4;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV_X = 5'b00010,
        S_DIV_Y = 5'b00100,
        S_OFS   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic               write_valid;
        logic [OFS_W-1:0]   write_offset;
        logic [COLOR_W-1:0] new_red;
        logic [COLOR_W-1:0] new_green;
        logic [COLOR_W-1:0] new_blue;
        logic               read_valid;
        logic [OFS_W-1:0]   read_offset;
        logic               last_pixel;
    } t_result;

endpackage

@@ rtl/dla_in_if.sv @@
// Interface: input item channel (load or background step).
interface dla_in_if #(
    parameter int COORD_BITS = 12
) ();
    logic                  valid;
    logic                  ready;
    logic                  action;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    logic [7:0]            bg_red;
    logic [7:0]            bg_green;
    logic [7:0]            bg_blue;

    modport source (
        output valid, action, x_start, y_start, x_end, y_end, bg_red, bg_green, bg_blue,
        input  ready
    );
    modport sink (
        input  valid, action, x_start, y_start, x_end, y_end, bg_red, bg_green, bg_blue,
        output ready
    );
endinterface

@@ rtl/dla_out_if.sv @@
// Interface: result item channel (pixel write and next read request).
interface dla_out_if
    import dla_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               write_valid;
    logic [OFS_W-1:0]   write_offset;
    logic [COLOR_W-1:0] new_red;
    logic [COLOR_W-1:0] new_green;
    logic [COLOR_W-1:0] new_blue;
    logic               read_valid;
    logic [OFS_W-1:0]   read_offset;
    logic               last_pixel;

    modport source (
        output valid, write_valid, write_offset, new_red, new_green, new_blue,
               read_valid, read_offset, last_pixel,
        input  ready
    );
    modport sink (
        input  valid, write_valid, write_offset, new_red, new_green, new_blue,
               read_valid, read_offset, last_pixel,
        output ready
    );
endinterface

@@ rtl/dla_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module dla_div #(
    parameter int N_W = 28,
    parameter int D_W = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [N_W-1:0] i_dividend,
    input  logic [D_W-1:0] i_divisor,
    output logic           o_done,
    output logic [N_W-1:0] o_quotient
);
    localparam int CNT_W = (N_W > 1) ? $clog2(N_W) : 1;

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [D_W:0]     r_rem, n_rem;
    logic [N_W-1:0]   r_quo, n_quo;
    logic [D_W-1:0]   r_div, n_div;
    logic [D_W:0]     rem_sh;
    logic             fits;

    assign rem_sh = {r_rem[D_W-1:0], r_quo[N_W-1]};
    assign fits   = rem_sh >= {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(N_W - 1);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_div  = i_divisor;
        end else if (r_busy) begin
            // shift in the next dividend bit, subtract when it fits
            n_rem = fits ? (rem_sh - {1'b0, r_div}) : rem_sh;
            n_quo = {r_quo[N_W-2:0], fits};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule

@@ rtl/dda_line_alpha_blend_unit.sv @@
// Top level: DDA line walker with constant-alpha blending of each drawn pixel.
//
// A load item (action 0) latches the end points of a line. The larger of the
// absolute X and Y deltas becomes the step count; one shared radix-2 divider
// then computes the signed Q.FRAC_BITS increments, X first and Y second, and
// the result item carries the byte offset of the first point to fetch. Each
// step item (action 1) brings the background BGR of the current point; its
// result is the blended color (color*a + bg*(256-a)) >> 8 per channel, the
// offset being written, and the offset of the next point to fetch, or the
// last-pixel flag when the line ends. A zero-length line draws one pixel.
// A load while a line is running abandons it; a step with no line running
// yields an all-zero result. Alpha above 256 counts as opaque. Offsets are
// trunc(y)*row_stride_bytes + trunc(x)*bytes_per_pixel, wrapped to 26 bits.
// Rate: one item at a time. A load runs the bit-serial divider once per axis,
// X then Y, then computes the first offset and hands off the result; a
// zero-length load skips the divider. A step blends and updates the position,
// runs the offset multiply, then hands off the result; the final step of a
// line and a step with no line running skip the offset multiply. Each waits
// while the result register is held by the sink. Configuration must only be
// written while the block is idle.
`include "dda_line_alpha_blend_unit_macros.svh"

module dda_line_alpha_blend_unit
    import dla_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dla_in_if.sink                i_pix,
    dla_out_if.source             o_res
);
    localparam int POS_W  = COORD_BITS + FRAC_BITS + 1;  // signed position
    localparam int STEP_W = FRAC_BITS + 2;                // signed increment
    localparam int PTS_W  = COORD_BITS + 1;               // points left
    localparam int DIV_W  = COORD_BITS + FRAC_BITS;       // dividend width
    localparam int SUM_W  = (COORD_BITS + STRIDE_W + 1 > OFS_W) ?
                            (COORD_BITS + STRIDE_W + 1) : OFS_W;

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] r_line_color;
    logic [ALPHA_W-1:0]    r_blend_alpha;
    logic [STRIDE_W-1:0]   r_row_stride;
    logic [BPP_W-1:0]      r_bpp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_color  <= LINE_COLOR_RST;
            r_blend_alpha <= ALPHA_ONE;
            r_row_stride  <= ROW_STRIDE_RST;
            r_bpp         <= BPP_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_LINE_COLOR:  r_line_color  <= i_cfg_data;
                CFG_BLEND_ALPHA: r_blend_alpha <= i_cfg_data[ALPHA_W-1:0];
                CFG_ROW_STRIDE:  r_row_stride  <= i_cfg_data[STRIDE_W-1:0];
                CFG_BPP:         r_bpp         <= i_cfg_data[BPP_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Line state and sequencer registers
    // ---------------------------------------------------------------------
    t_state                    r_state, n_state;
    logic                      r_line_busy, n_line_busy;
    logic signed [POS_W-1:0]   r_x_pos, n_x_pos;
    logic signed [POS_W-1:0]   r_y_pos, n_y_pos;
    logic signed [STEP_W-1:0]  r_x_step, n_x_step;
    logic signed [STEP_W-1:0]  r_y_step, n_y_step;
    logic [PTS_W-1:0]          r_points_left, n_points_left;
    logic [OFS_W-1:0]          r_cur_offset, n_cur_offset;
    logic                      r_dx_neg, n_dx_neg;
    logic                      r_dy_neg, n_dy_neg;
    logic [COORD_BITS-1:0]     r_ay, n_ay;
    logic [COORD_BITS-1:0]     r_steps, n_steps;
    t_result                   r_res, n_res;      // result being assembled
    t_result                   r_out, n_out;      // output register
    logic                      r_out_valid, n_out_valid;

    // Blend one channel as bg*256 + (fg-bg)*a, which equals
    // fg*a + bg*(256-a) and needs a single small multiply.
    function automatic logic [COLOR_W-1:0] blend_ch(
        input logic [COLOR_W-1:0] fg,
        input logic [COLOR_W-1:0] bg,
        input logic [ALPHA_W-1:0] a
    );
        logic signed [COLOR_W:0]   diff;
        logic signed [ALPHA_W:0]   sa;
        logic signed [19:0]        prod;
        logic signed [19:0]        total;
        diff  = $signed({1'b0, fg}) - $signed({1'b0, bg});
        sa    = $signed({1'b0, a});
        prod  = 20'(diff) * 20'(sa);
        total = $signed({4'b0000, bg, 8'h00}) + prod;
        return total[15:8];
    endfunction

    // Integer part of a position; a negative one clamps to zero.
    function automatic logic [COORD_BITS-1:0] coord_of(
        input logic signed [POS_W-1:0] pos
    );
        return pos[POS_W-1] ? '0 : pos[COORD_BITS+FRAC_BITS-1:FRAC_BITS];
    endfunction

    // ---------------------------------------------------------------------
    // Load datapath: deltas and step count straight from the input item
    // ---------------------------------------------------------------------
    logic                  accept;
    logic                  dx_neg_c, dy_neg_c;
    logic [COORD_BITS-1:0] ax_c, ay_c, steps_c;

    assign accept   = i_pix.valid && i_pix.ready;
    assign dx_neg_c = i_pix.x_end < i_pix.x_start;
    assign dy_neg_c = i_pix.y_end < i_pix.y_start;
    assign ax_c     = dx_neg_c ? (i_pix.x_start - i_pix.x_end) : (i_pix.x_end - i_pix.x_start);
    assign ay_c     = dy_neg_c ? (i_pix.y_start - i_pix.y_end) : (i_pix.y_end - i_pix.y_start);
    assign steps_c  = (ax_c > ay_c) ? ax_c : ay_c;

    // ---------------------------------------------------------------------
    // Shared divider: X increment on load, then Y increment
    // ---------------------------------------------------------------------
    logic              div_start;
    logic              div_done;
    logic [DIV_W-1:0]  div_dividend;
    logic [COORD_BITS-1:0] div_divisor;
    logic [DIV_W-1:0]  div_quo;
    logic [STEP_W-1:0] q_mag;

    assign div_start = (r_state == S_IDLE && accept && !i_pix.action && steps_c != '0) ||
                       (r_state == S_DIV_X && div_done);
    assign div_dividend = (r_state == S_IDLE) ? {ax_c, {FRAC_BITS{1'b0}}} :
                                                {r_ay, {FRAC_BITS{1'b0}}};
    assign div_divisor  = (r_state == S_IDLE) ? steps_c : r_steps;
    // |delta| <= steps, so the quotient never exceeds 1.0
    assign q_mag = {1'b0, div_quo[FRAC_BITS:0]};

    dla_div #(
        .N_W (DIV_W),
        .D_W (COORD_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // ---------------------------------------------------------------------
    // Offset of the current position: one multiply plus a small one
    // ---------------------------------------------------------------------
    logic [SUM_W-1:0] ofs_sum;
    logic [OFS_W-1:0] ofs_c;

    assign ofs_sum = SUM_W'(coord_of(r_y_pos)) * SUM_W'(r_row_stride) +
                     SUM_W'(coord_of(r_x_pos)) * SUM_W'(r_bpp);
    assign ofs_c   = ofs_sum[OFS_W-1:0];

    // ---------------------------------------------------------------------
    // Blend of the incoming background
    // ---------------------------------------------------------------------
    logic [ALPHA_W-1:0] alpha_sat;
    assign alpha_sat = (r_blend_alpha > ALPHA_ONE) ? ALPHA_ONE : r_blend_alpha;

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        n_state       = r_state;
        n_line_busy   = r_line_busy;
        n_x_pos       = r_x_pos;
        n_y_pos       = r_y_pos;
        n_x_step      = r_x_step;
        n_y_step      = r_y_step;
        n_points_left = r_points_left;
        n_cur_offset  = r_cur_offset;
        n_dx_neg      = r_dx_neg;
        n_dy_neg      = r_dy_neg;
        n_ay          = r_ay;
        n_steps       = r_steps;
        n_res         = r_res;
        n_out         = r_out;
        n_out_valid   = r_out_valid;

        // drop the output item once the sink takes it
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_res = '0;
                    if (!i_pix.action) begin
                        // load: abandon any running line and start this one
                        n_dx_neg      = dx_neg_c;
                        n_dy_neg      = dy_neg_c;
                        n_ay          = ay_c;
                        n_steps       = steps_c;
                        n_x_pos       = POS_W'({i_pix.x_start, {FRAC_BITS{1'b0}}});
                        n_y_pos       = POS_W'({i_pix.y_start, {FRAC_BITS{1'b0}}});
                        n_points_left = PTS_W'(steps_c) + PTS_W'(1);
                        n_line_busy   = 1'b1;
                        if (steps_c == '0) begin
                            // zero-length line: one pixel, no movement
                            n_x_step = '0;
                            n_y_step = '0;
                            n_state  = S_OFS;
                        end else begin
                            n_state = S_DIV_X;
                        end
                    end else if (r_line_busy) begin
                        n_res.write_valid  = 1'b1;
                        n_res.write_offset = r_cur_offset;
                        n_res.new_red   = blend_ch(r_line_color[23:16], i_pix.bg_red, alpha_sat);
                        n_res.new_green = blend_ch(r_line_color[15:8], i_pix.bg_green, alpha_sat);
                        n_res.new_blue  = blend_ch(r_line_color[7:0], i_pix.bg_blue, alpha_sat);
                        n_x_pos       = r_x_pos + POS_W'(r_x_step);
                        n_y_pos       = r_y_pos + POS_W'(r_y_step);
                        n_points_left = r_points_left - PTS_W'(1);
                        if (r_points_left == PTS_W'(1)) begin
                            // last pixel: no further read, go idle
                            n_line_busy      = 1'b0;
                            n_cur_offset     = '0;
                            n_res.last_pixel = 1'b1;
                            n_state          = S_EMIT;
                        end else begin
                            n_state = S_OFS;
                        end
                    end else begin
                        // step with no line running: all-zero result
                        n_state = S_EMIT;
                    end
                end
            end
            S_DIV_X: begin
                if (div_done) begin
                    n_x_step = r_dx_neg ? -q_mag : q_mag;
                    n_state  = S_DIV_Y;
                end
            end
            S_DIV_Y: begin
                if (div_done) begin
                    n_y_step = r_dy_neg ? -q_mag : q_mag;
                    n_state  = S_OFS;
                end
            end
            S_OFS: begin
                n_cur_offset      = ofs_c;
                n_res.read_valid  = 1'b1;
                n_res.read_offset = ofs_c;
                n_state           = S_EMIT;
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!r_out_valid || o_res.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_line_busy <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_line_busy <= n_line_busy;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x_pos       <= n_x_pos;
        r_y_pos       <= n_y_pos;
        r_x_step      <= n_x_step;
        r_y_step      <= n_y_step;
        r_points_left <= n_points_left;
        r_cur_offset  <= n_cur_offset;
        r_dx_neg      <= n_dx_neg;
        r_dy_neg      <= n_dy_neg;
        r_ay          <= n_ay;
        r_steps       <= n_steps;
        r_res         <= n_res;
        r_out         <= n_out;
    end

    // ---------------------------------------------------------------------
    // Ports
    // ---------------------------------------------------------------------
    assign i_pix.ready        = (r_state == S_IDLE);
    assign o_res.valid        = r_out_valid;
    assign o_res.write_valid  = r_out.write_valid;
    assign o_res.write_offset = r_out.write_offset;
    assign o_res.new_red      = r_out.new_red;
    assign o_res.new_green    = r_out.new_green;
    assign o_res.new_blue     = r_out.new_blue;
    assign o_res.read_valid   = r_out.read_valid;
    assign o_res.read_offset  = r_out.read_offset;
    assign o_res.last_pixel   = r_out.last_pixel;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `DLA_ASSERT_SAME(a_busy_has_points, i_clk, i_rst_n, r_line_busy, r_points_left != '0, "line running with no points left")
    `DLA_ASSERT_SAME(a_div_done_in_div, i_clk, i_rst_n, div_done, r_state == S_DIV_X || r_state == S_DIV_Y, "divider finished outside a divide state")
    `DLA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, accept, r_state != S_IDLE, "accepted item did not start work")
    `DLA_ASSERT_SAME(a_last_ends_line, i_clk, i_rst_n, r_out_valid && r_out.last_pixel, !r_out.read_valid, "last pixel carries a read request")
endmodule

@@ tb/sv/tb.sv @@
// Self-checking bench for the DDA line walker with alpha blending of drawn pixels.
module tb;
    import dla_pkg::*;

    localparam int COORD_BITS    = 12;
    localparam int FRAC_BITS     = 16;
    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;
    localparam int HALF_PERIOD   = 6;
    localparam int SETTLE_CYCLES = 80;    // time for a running load to finish
    localparam int STALL_LIMIT   = 5000;  // cycles with no item moving on either side
    localparam int MAX_REPORTS   = 10;
    localparam int ITEMS_PER_HALF = 150;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_STEP = 1'b1
    } pix_action_e;

    typedef struct packed {
        pix_action_e           action;
        logic [COORD_BITS-1:0] x_start;
        logic [COORD_BITS-1:0] y_start;
        logic [COORD_BITS-1:0] x_end;
        logic [COORD_BITS-1:0] y_end;
        logic [7:0]            bg_red;
        logic [7:0]            bg_green;
        logic [7:0]            bg_blue;
    } pix_item_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_wr_en;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    dla_in_if #(.COORD_BITS(COORD_BITS)) pix_if ();
    dla_out_if                           res_if ();

    dda_line_alpha_blend_unit #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Items waiting to be offered, and pixel results the walker still owes us.
    pix_item_t pending_items[$];
    t_result   expected_pixels[$];

    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  in_took     = 1'b0;   // an input item moved at the last rising edge
    bit  gen_idle    = 1'b1;   // no line is open once the queued items have run
    int  mismatches  = 0;
    int  idle_cycles = 0;

    // Shadow of the configuration registers, at their reset values.
    logic [23:0]         fg_color    = LINE_COLOR_RST;
    logic [ALPHA_W-1:0]  blend_level = ALPHA_ONE;
    logic [STRIDE_W-1:0] row_pitch   = ROW_STRIDE_RST;
    logic [BPP_W-1:0]    pix_bytes   = BPP_RST;

    // Shadow of the line walker: Q.16 positions, Q1.16 increments.
    bit               line_open    = 1'b0;
    longint           pos_x        = 0;
    longint           pos_y        = 0;
    longint           inc_x        = 0;
    longint           inc_y        = 0;
    int               points_to_go = 0;
    logic [OFS_W-1:0] next_ofs     = '0;

    // Byte offset of the current position; truncate the fraction, clamp below zero.
    function automatic logic [OFS_W-1:0] pixel_offset();
        longint cx;
        longint cy;
        cx = (pos_x < 0) ? 0 : (pos_x >>> FRAC_BITS);
        cy = (pos_y < 0) ? 0 : (pos_y >>> FRAC_BITS);
        return OFS_W'(cy * longint'(row_pitch) + cx * longint'(pix_bytes));
    endfunction

    // Signed per-step increment, magnitude truncated toward zero.
    function automatic longint axis_increment(longint delta, longint steps);
        longint mag;
        if (steps == 0) begin
            return 0;
        end
        mag = ((delta < 0 ? -delta : delta) << FRAC_BITS) / steps;
        return (delta < 0) ? -mag : mag;
    endfunction

    function automatic logic [7:0] blend_channel(logic [7:0] fg, logic [7:0] bg, int a);
        int mixed;
        mixed = int'(fg) * a + int'(bg) * (256 - a);
        return 8'(mixed >> 8);
    endfunction

    // Advance the shadow walker by one item and return the pixel result it yields.
    function automatic t_result predict_pixel(pix_item_t it);
        t_result r;
        longint  dx;
        longint  dy;
        longint  ax;
        longint  ay;
        longint  steps;
        int      a;
        r = '0;
        if (it.action == ACT_LOAD) begin
            dx = longint'(it.x_end) - longint'(it.x_start);
            dy = longint'(it.y_end) - longint'(it.y_start);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;
            steps = (ax > ay) ? ax : ay;
            inc_x = axis_increment(dx, steps);
            inc_y = axis_increment(dy, steps);
            pos_x = longint'(it.x_start) <<< FRAC_BITS;
            pos_y = longint'(it.y_start) <<< FRAC_BITS;
            points_to_go = int'(steps) + 1;
            line_open = 1'b1;
            next_ofs = pixel_offset();
            r.read_valid  = 1'b1;
            r.read_offset = next_ofs;
        end else if (line_open) begin
            // Saturate alpha above one to opaque.
            a = (blend_level > ALPHA_ONE) ? 256 : int'(blend_level);
            r.write_valid  = 1'b1;
            r.write_offset = next_ofs;
            r.new_red      = blend_channel(fg_color[23:16], it.bg_red, a);
            r.new_green    = blend_channel(fg_color[15:8], it.bg_green, a);
            r.new_blue     = blend_channel(fg_color[7:0], it.bg_blue, a);
            pos_x += inc_x;
            pos_y += inc_y;
            if (points_to_go > 0) begin
                points_to_go--;
            end
            if (points_to_go == 0) begin
                line_open     = 1'b0;
                next_ofs      = '0;
                r.last_pixel  = 1'b1;
            end else begin
                next_ofs      = pixel_offset();
                r.read_valid  = 1'b1;
                r.read_offset = next_ofs;
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Item builders: they only fill the queue, the driver paces it.
    // ---------------------------------------------------------------
    function automatic void add_load(int xs, int ys, int xe, int ye);
        pending_items.push_back('{ACT_LOAD, COORD_BITS'(xs), COORD_BITS'(ys),
                                  COORD_BITS'(xe), COORD_BITS'(ye),
                                  8'($urandom_range(255)), 8'($urandom_range(255)),
                                  8'($urandom_range(255))});
    endfunction

    // Coordinates ride along as noise: the walker ignores them on a step.
    function automatic void add_step(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        pending_items.push_back('{ACT_STEP, COORD_BITS'($urandom_range(COORD_MAX)),
                                  COORD_BITS'($urandom_range(COORD_MAX)),
                                  COORD_BITS'($urandom_range(COORD_MAX)),
                                  COORD_BITS'($urandom_range(COORD_MAX)), r, g, b});
    endfunction

    function automatic void add_steps(int n);
        for (int k = 0; k < n; k++) begin
            add_step(8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255)));
        end
    endfunction

    // Single-pixel line: the start point repeated as the end point.
    function automatic void add_zero_line();
        int xs;
        int ys;
        xs = $urandom_range(COORD_MAX);
        ys = $urandom_range(COORD_MAX);
        add_load(xs, ys, xs, ys);
        add_steps(1);
        gen_idle = 1'b1;
    endfunction

    // Mostly complete lines of short length; some abandoned lines and stray steps.
    function automatic void add_traffic(int n_items);
        int first;
        int pick;
        int len;
        int dmaj;
        int dmin;
        int dx;
        int dy;
        int xs;
        int ys;
        int xe;
        int ye;
        int n;
        first = pending_items.size();
        while (pending_items.size() - first < n_items) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                len = $urandom_range(99);
                len = (len < 80) ? $urandom_range(15) :
                      (len < 98) ? $urandom_range(100, 16) : $urandom_range(400, 101);
                dmaj = len;
                dmin = $urandom_range(len);
                dx = $urandom_range(1) ? dmaj : dmin;
                dy = (dx == dmaj) ? dmin : dmaj;
                if ($urandom_range(1)) dx = -dx;
                if ($urandom_range(1)) dy = -dy;
                xs = $urandom_range(COORD_MAX);
                ys = $urandom_range(COORD_MAX);
                xe = xs + dx;
                ye = ys + dy;
                if (xe > COORD_MAX || xe < 0) xe = xs - dx;
                if (ye > COORD_MAX || ye < 0) ye = ys - dy;
                add_load(xs, ys, xe, ye);
                add_steps(len + 1);
                gen_idle = 1'b1;
            end else if (pick < 82) begin
                add_zero_line();
            end else if (pick < 92) begin
                // Open a line anywhere and walk only part of it.
                xs = $urandom_range(COORD_MAX);
                ys = $urandom_range(COORD_MAX);
                xe = $urandom_range(COORD_MAX);
                ye = $urandom_range(COORD_MAX);
                dx = (xe > xs) ? xe - xs : xs - xe;
                dy = (ye > ys) ? ye - ys : ys - ye;
                n = (dx > dy) ? dx : dy;
                add_load(xs, ys, xe, ye);
                add_steps($urandom_range((n < 8) ? n : 8));
                gen_idle = 1'b0;
            end else if (gen_idle) begin
                add_steps($urandom_range(2, 1));
            end
        end
    endfunction

    // ---------------------------------------------------------------
    // Configuration writes, only while nothing is in flight.
    // ---------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        case (idx)
            CFG_LINE_COLOR: begin
                fg_color = value[23:0];
            end
            CFG_BLEND_ALPHA: begin
                blend_level = value[ALPHA_W-1:0];
            end
            CFG_ROW_STRIDE: begin
                row_pitch = value[STRIDE_W-1:0];
            end
            CFG_BPP: begin
                pix_bytes = value[BPP_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    task automatic write_cfg_set(int color, int alpha, int stride, int bpp);
        write_reg(CFG_LINE_COLOR, CFG_DATA_W'(color));
        write_reg(CFG_BLEND_ALPHA, CFG_DATA_W'(alpha));
        write_reg(CFG_ROW_STRIDE, CFG_DATA_W'(stride));
        write_reg(CFG_BPP, CFG_DATA_W'(bpp));
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Hold off until every queued item went in and every result came out.
    task automatic drain();
        while (pending_items.size() != 0 || expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One configuration, then two bursts with a full drain in between.
    task automatic run_segment(int color, int alpha, int stride, int bpp);
        drain();
        write_cfg_set(color, alpha, stride, bpp);
        add_traffic(ITEMS_PER_HALF);
        drain();
        add_traffic(ITEMS_PER_HALF);
        // Close any abandoned line so the next setting starts from idle.
        if (!gen_idle) begin
            add_zero_line();
        end
    endtask

    task automatic check_field(string name, logic [OFS_W-1:0] want, logic [OFS_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            end
        end
    endtask

    // ---------------------------------------------------------------
    // Driver: change inputs at the falling edge only.
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
        if (!i_rst_n) begin
            pix_if.valid <= 1'b0;
        end else if (!pix_if.valid || in_took) begin
            // Offer the head of the queue unless this cycle is an idle one.
            if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                pix_if.valid    <= 1'b1;
                pix_if.action   <= pending_items[0].action;
                pix_if.x_start  <= pending_items[0].x_start;
                pix_if.y_start  <= pending_items[0].y_start;
                pix_if.x_end    <= pending_items[0].x_end;
                pix_if.y_end    <= pending_items[0].y_end;
                pix_if.bg_red   <= pending_items[0].bg_red;
                pix_if.bg_green <= pending_items[0].bg_green;
                pix_if.bg_blue  <= pending_items[0].bg_blue;
            end else begin
                pix_if.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: sample both channels at the rising edge, predict, compare.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : watch_ports
        t_result got;
        t_result want;
        bit      out_fire;
        in_took  = i_rst_n && pix_if.valid && pix_if.ready;
        out_fire = i_rst_n && res_if.valid && res_if.ready;
        if (in_took) begin
            expected_pixels.push_back(predict_pixel(pending_items.pop_front()));
        end
        if (out_fire) begin
            got = {res_if.write_valid, res_if.write_offset, res_if.new_red,
                   res_if.new_green, res_if.new_blue, res_if.read_valid,
                   res_if.read_offset, res_if.last_pixel};
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: result with nothing expected: %h", $time, got);
                end
            end else begin
                want = expected_pixels.pop_front();
                check_field("write_valid", OFS_W'(want.write_valid), OFS_W'(got.write_valid));
                check_field("write_offset", want.write_offset, got.write_offset);
                check_field("new_red", OFS_W'(want.new_red), OFS_W'(got.new_red));
                check_field("new_green", OFS_W'(want.new_green), OFS_W'(got.new_green));
                check_field("new_blue", OFS_W'(want.new_blue), OFS_W'(got.new_blue));
                check_field("read_valid", OFS_W'(want.read_valid), OFS_W'(got.read_valid));
                check_field("read_offset", want.read_offset, got.read_offset);
                check_field("last_pixel", OFS_W'(want.last_pixel), OFS_W'(got.last_pixel));
            end
        end
        // Watchdog: give up when nothing moves for too long.
        if (in_took || out_fire) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequence: reset, directed items, then six configuration settings.
    // ---------------------------------------------------------------
    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        pix_if.valid    = 1'b0;
        pix_if.action   = ACT_LOAD;
        pix_if.x_start  = '0;
        pix_if.y_start  = '0;
        pix_if.x_end    = '0;
        pix_if.y_end    = '0;
        pix_if.bg_red   = '0;
        pix_if.bg_green = '0;
        pix_if.bg_blue  = '0;
        res_if.ready    = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sender mostly busy, receiver mostly stalled.
        tx_idle_pct = 23;
        rx_idle_pct = 66;

        // Directed part, with the reset configuration.
        add_step(8'h00, 8'hFF, 8'h5A);                 // step with no line open
        add_load(100, 200, 100, 200);                  // zero-length line
        add_step(8'hFF, 8'hFF, 8'hFF);
        add_load(0, 0, COORD_MAX, COORD_MAX);          // full diagonal, left open
        add_step(8'h00, 8'h00, 8'h00);
        add_step(8'hFF, 8'h00, 8'hFF);
        add_load(COORD_MAX, COORD_MAX, 0, 0);          // load abandons the line
        add_step(8'h00, 8'hFF, 8'h00);
        add_step(8'h80, 8'h7F, 8'h01);
        add_load(0, COORD_MAX, COORD_MAX, 0);
        add_step(8'hFE, 8'h01, 8'hAA);
        add_load(10, 5, 13, 5);                        // horizontal, walked to the end
        add_steps(4);
        add_load(7, 3, 7, 0);                          // vertical upward, to the end
        add_steps(4);
        add_step(8'h55, 8'hAA, 8'h33);                 // stray step after the last pixel
        gen_idle = 1'b1;

        run_segment(24'hFFFFFF, 0, 1, 2);
        run_segment(24'h000000, 256, 16384, 4);

        // Sender mostly idle, receiver mostly ready.
        drain();
        tx_idle_pct = 66;
        rx_idle_pct = 23;
        // Alpha above one, and a stride and pixel size that wrap the offset.
        run_segment($urandom_range(24'hFFFFFF), 511, 32767, 7);
        run_segment($urandom_range(24'hFFFFFF), 128, 640, 3);

        // No idling on either side.
        drain();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_segment($urandom_range(24'hFFFFFF), $urandom_range(511), $urandom_range(32767, 1),
                    $urandom_range(7));
        run_segment($urandom_range(24'hFFFFFF), $urandom_range(255, 1),
                    $urandom_range(16384, 1), $urandom_range(4, 2));

        drain();
        if (mismatches == 0 && expected_pixels.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/dla_pkg.sv
rtl/dla_in_if.sv
rtl/dla_out_if.sv
rtl/dla_div.sv
rtl/dda_line_alpha_blend_unit.sv
tb/sv/tb.sv
